/* rtl/core/alad_pkg.sv */
// Shared types and constants of the analog limit alarm.
`default_nettype none
package alad_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // Input function codes
    localparam logic [1:0] FN_SAMPLE = 2'd0;
    localparam logic [1:0] FN_TICK   = 2'd1;
    localparam logic [1:0] FN_INIT   = 2'd2;

    // Event codes
    localparam logic [2:0] EVT_HIGH_ON  = 3'd0;
    localparam logic [2:0] EVT_HIGH_OFF = 3'd1;
    localparam logic [2:0] EVT_LOW_ON   = 3'd2;
    localparam logic [2:0] EVT_LOW_OFF  = 3'd3;
    localparam logic [2:0] EVT_DRIFT    = 3'd4;

    localparam logic PRI_HI = 1'b1;

    // Alarm flag bit positions
    localparam int unsigned FL_HSET = 0;
    localparam int unsigned FL_HREM = 1;
    localparam int unsigned FL_LSET = 2;
    localparam int unsigned FL_LREM = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_RELEASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_THRESH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PRIO    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_EN      = 3'd7;

    // Event queue between front and back
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // Events fired by one tick: fire[0] high timer, fire[1] low, fire[2] change
    typedef struct packed {
        logic [2:0]          fire;
        logic                hi_set;
        logic                lo_set;
        logic                hi_urg;
        logic                lo_urg;
        logic [SAMPLE_W-1:0] value;
    } t_evt_bundle;

endpackage
`default_nettype wire

/* rtl/core/alad_front.sv */
// Front end: configuration registers, channel state and per-item classification.
`default_nettype none
module alad_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_func,
    input  wire logic [alad_pkg::SAMPLE_W-1:0]      i_sample_value,
    input  wire logic                               i_cfg_we,
    input  wire logic [alad_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire logic [alad_pkg::CFG_DAT_W-1:0]     i_cfg_wdata,
    input  wire logic                               i_q_full,
    output logic                                    o_q_push,
    output alad_pkg::t_evt_bundle                   o_q_data
);

    logic [alad_pkg::SAMPLE_W-1:0] r_high_limit, r_high_release, r_low_release, r_low_limit;
    logic [alad_pkg::SAMPLE_W-1:0] r_dev_thresh;
    logic [alad_pkg::COUNT_W-1:0]  r_delay;
    logic                          r_high_prio, r_chan_en;

    logic [alad_pkg::SAMPLE_W-1:0] r_cur, n_cur, r_ref, n_ref;
    logic [3:0]                    r_flags, n_flags;
    logic                          r_hi_act, n_hi_act, r_hi_set, n_hi_set;
    logic                          r_lo_act, n_lo_act, r_lo_set, n_lo_set;
    logic                          r_chg_act, n_chg_act;
    logic [alad_pkg::COUNT_W-1:0]  r_hi_cnt, n_hi_cnt, r_lo_cnt, n_lo_cnt;
    logic [alad_pkg::COUNT_W-1:0]  r_chg_cnt, n_chg_cnt;

    logic                          accept;
    logic [alad_pkg::SAMPLE_W-1:0] v, diff;
    logic [2:0]                    fire;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign v          = i_sample_value;
    assign diff       = (v >= r_ref) ? (v - r_ref) : (r_ref - v);

    always_comb begin
        n_cur     = r_cur;
        n_ref     = r_ref;
        n_flags   = r_flags;
        n_hi_act  = r_hi_act;
        n_hi_set  = r_hi_set;
        n_hi_cnt  = r_hi_cnt;
        n_lo_act  = r_lo_act;
        n_lo_set  = r_lo_set;
        n_lo_cnt  = r_lo_cnt;
        n_chg_act = r_chg_act;
        n_chg_cnt = r_chg_cnt;
        fire      = 3'b000;
        if (accept) begin
            case (i_func)
                alad_pkg::FN_SAMPLE: begin
                    n_cur = v;
                    if (r_chan_en) begin
                        if (diff > r_dev_thresh) begin
                            n_chg_act = 1'b1;
                            n_chg_cnt = r_delay;
                            n_ref     = v;
                        end
                        // later starts override earlier ones
                        if (v >= r_high_limit && !n_flags[alad_pkg::FL_HSET]) begin
                            n_flags[alad_pkg::FL_HSET] = 1'b1;
                            n_flags[alad_pkg::FL_HREM] = 1'b0;
                            n_hi_act = 1'b1;
                            n_hi_cnt = r_delay;
                            n_hi_set = 1'b1;
                        end
                        if (v < r_high_release && !n_flags[alad_pkg::FL_HREM]) begin
                            n_flags[alad_pkg::FL_HREM] = 1'b1;
                            n_flags[alad_pkg::FL_HSET] = 1'b0;
                            n_hi_act = 1'b1;
                            n_hi_cnt = r_delay;
                            n_hi_set = 1'b0;
                        end
                        if (v > r_low_release && !n_flags[alad_pkg::FL_LREM]) begin
                            n_flags[alad_pkg::FL_LREM] = 1'b1;
                            n_flags[alad_pkg::FL_LSET] = 1'b0;
                            n_lo_act = 1'b1;
                            n_lo_cnt = r_delay;
                            n_lo_set = 1'b0;
                        end
                        if (v < r_low_limit && !n_flags[alad_pkg::FL_LSET]) begin
                            n_flags[alad_pkg::FL_LSET] = 1'b1;
                            n_flags[alad_pkg::FL_LREM] = 1'b0;
                            n_lo_act = 1'b1;
                            n_lo_cnt = r_delay;
                            n_lo_set = 1'b1;
                        end
                    end
                end
                alad_pkg::FN_INIT: begin
                    n_cur = v;
                    n_ref = v;
                    if (v >= r_high_limit) begin
                        n_flags = 4'b0000;
                        n_flags[alad_pkg::FL_HSET] = 1'b1;
                        n_flags[alad_pkg::FL_LREM] = 1'b1;
                    end
                    if (v <= r_low_limit) begin
                        n_flags = 4'b0000;
                        n_flags[alad_pkg::FL_LSET] = 1'b1;
                        n_flags[alad_pkg::FL_HREM] = 1'b1;
                    end
                    if (v <= r_high_release && v >= r_low_release) begin
                        n_flags = 4'b0000;
                        n_flags[alad_pkg::FL_HREM] = 1'b1;
                        n_flags[alad_pkg::FL_LREM] = 1'b1;
                    end
                end
                alad_pkg::FN_TICK: begin
                    if (r_hi_act) begin
                        n_hi_cnt = r_hi_cnt - 8'd1;
                        if (n_hi_cnt == '0) begin
                            n_hi_act = 1'b0;
                            fire[0]  = 1'b1;
                        end
                    end
                    if (r_lo_act) begin
                        n_lo_cnt = r_lo_cnt - 8'd1;
                        if (n_lo_cnt == '0) begin
                            n_lo_act = 1'b0;
                            fire[1]  = 1'b1;
                        end
                    end
                    if (r_chg_act) begin
                        n_chg_cnt = r_chg_cnt - 8'd1;
                        if (n_chg_cnt == '0) begin
                            n_chg_act = 1'b0;
                            fire[2]   = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_q_push        = |fire;
    assign o_q_data.fire   = fire;
    assign o_q_data.hi_set = r_hi_set;
    assign o_q_data.lo_set = r_lo_set;
    assign o_q_data.hi_urg = (r_high_prio == alad_pkg::PRI_HI) && r_hi_set;
    assign o_q_data.lo_urg = (r_high_prio == alad_pkg::PRI_HI) && r_lo_set;
    assign o_q_data.value  = r_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_limit   <= '1;
            r_high_release <= '1;
            r_low_release  <= '0;
            r_low_limit    <= '0;
            r_dev_thresh   <= '1;
            r_delay        <= 8'd1;
            r_high_prio    <= 1'b0;
            r_chan_en      <= 1'b0;
            r_cur          <= '0;
            r_ref          <= '0;
            r_flags        <= '0;
            r_hi_act       <= 1'b0;
            r_hi_set       <= 1'b0;
            r_hi_cnt       <= '0;
            r_lo_act       <= 1'b0;
            r_lo_set       <= 1'b0;
            r_lo_cnt       <= '0;
            r_chg_act      <= 1'b0;
            r_chg_cnt      <= '0;
        end else begin
            r_cur     <= n_cur;
            r_ref     <= n_ref;
            r_flags   <= n_flags;
            r_hi_act  <= n_hi_act;
            r_hi_set  <= n_hi_set;
            r_hi_cnt  <= n_hi_cnt;
            r_lo_act  <= n_lo_act;
            r_lo_set  <= n_lo_set;
            r_lo_cnt  <= n_lo_cnt;
            r_chg_act <= n_chg_act;
            r_chg_cnt <= n_chg_cnt;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    alad_pkg::REG_HIGH_LIMIT:   r_high_limit   <= i_cfg_wdata;
                    alad_pkg::REG_HIGH_RELEASE: r_high_release <= i_cfg_wdata;
                    alad_pkg::REG_LOW_RELEASE:  r_low_release  <= i_cfg_wdata;
                    alad_pkg::REG_LOW_LIMIT:    r_low_limit    <= i_cfg_wdata;
                    alad_pkg::REG_DEV_THRESH:   r_dev_thresh   <= i_cfg_wdata;
                    alad_pkg::REG_DELAY_TICKS:  r_delay        <= i_cfg_wdata[alad_pkg::COUNT_W-1:0];
                    alad_pkg::REG_HIGH_PRIO:    r_high_prio    <= i_cfg_wdata[0];
                    alad_pkg::REG_CHAN_EN:      r_chan_en      <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/alad_queue.sv */
// Small FIFO of tick event bundles between front and back.
`default_nettype none
module alad_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire alad_pkg::t_evt_bundle i_wdata,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output alad_pkg::t_evt_bundle      o_rdata
);

    alad_pkg::t_evt_bundle             r_mem [alad_pkg::QDEPTH];
    logic [alad_pkg::QPTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [alad_pkg::QCNT_W-1:0]       r_count;
    logic                              do_push, do_pop;

    assign o_full  = (r_count == alad_pkg::QCNT_W'(alad_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == alad_pkg::QPTR_W'(alad_pkg::QDEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == alad_pkg::QPTR_W'(alad_pkg::QDEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/alad_back.sv */
// Back end: unpacks each event bundle into result items, one per cycle while out_ready is high.
`default_nettype none
module alad_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_empty,
    input  wire alad_pkg::t_evt_bundle         i_q_data,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [2:0]                         o_event_code,
    output logic [alad_pkg::SAMPLE_W-1:0]      o_reported_value,
    output logic                               o_urgent,
    output logic                               o_last_of_run
);

    logic [2:0]            r_mask, n_mask;
    alad_pkg::t_evt_bundle r_bundle;
    logic                  single, load;
    logic [2:0]            drop_low;

    assign single   = ((r_mask & (r_mask - 3'd1)) == 3'b000);
    assign drop_low = r_mask & (r_mask - 3'd1);
    // take the next bundle when idle or when the last result is leaving
    assign load     = (r_mask == 3'b000) || (i_out_ready && single);
    assign o_q_pop  = load && !i_q_empty;

    always_comb begin
        if (load) begin
            n_mask = i_q_empty ? 3'b000 : i_q_data.fire;
        end else if (i_out_ready) begin
            n_mask = drop_low;
        end else begin
            n_mask = r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_bundle <= i_q_data;
        end
    end

    assign o_out_valid      = |r_mask;
    assign o_reported_value = r_bundle.value;
    assign o_last_of_run    = single;

    always_comb begin
        if (r_mask[0]) begin
            o_event_code = r_bundle.hi_set ? alad_pkg::EVT_HIGH_ON : alad_pkg::EVT_HIGH_OFF;
            o_urgent     = r_bundle.hi_urg;
        end else if (r_mask[1]) begin
            o_event_code = r_bundle.lo_set ? alad_pkg::EVT_LOW_ON : alad_pkg::EVT_LOW_OFF;
            o_urgent     = r_bundle.lo_urg;
        end else begin
            o_event_code = alad_pkg::EVT_DRIFT;
            o_urgent     = 1'b0;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/analog_limit_alarm_with_delay_top.sv */
// Top level of the analog limit alarm with hysteresis, change deadband and report delay.
//
// Samples, initial samples and ticks are accepted one per cycle while the event queue is
// not full; each is processed in the cycle it is accepted. A tick whose timers expire
// produces one to three results (high, then low, then change), delivered one per cycle
// from the back end while the output is ready, with last_of_run marking the final one.
// Up to two such ticks wait in the event queue between front and back; while the queue
// is full the input is not ready, so under load new input waits until results drain.
`default_nettype none
module analog_limit_alarm_with_delay_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_func,
    input  wire logic [alad_pkg::SAMPLE_W-1:0]      i_sample_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [2:0]                              o_event_code,
    output logic [alad_pkg::SAMPLE_W-1:0]           o_reported_value,
    output logic                                    o_urgent,
    output logic                                    o_last_of_run,
    input  wire logic                               i_cfg_we,
    input  wire logic [alad_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire logic [alad_pkg::CFG_DAT_W-1:0]     i_cfg_wdata
);

    logic                  q_push, q_full;
    alad_pkg::t_evt_bundle q_wdata, q_rdata;
    logic                  q_pop, q_empty;

    alad_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_sample_value (i_sample_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata)
    );

    alad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    alad_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_data         (q_rdata),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_event_code     (o_event_code),
        .o_reported_value (o_reported_value),
        .o_urgent         (o_urgent),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
`default_nettype wire
